>>> rtl/mcptd_pkg.sv
// Shared constants, types and helper functions of the piezo tap detector.
`default_nettype none
package mcptd_pkg;

    localparam int SIDE_COUNT    = 8;
    localparam int SIDE_BITS     = $clog2(SIDE_COUNT);
    localparam int SAMPLE_BITS   = 12;
    localparam int SEED_SCANS    = 100;
    localparam int AVERAGE_SHIFT = 6;
    localparam int TIME_BITS     = 32;

    localparam int MARGIN_BITS    = 12;
    localparam int DEBOUNCE_BITS  = 16;
    localparam int WINDOW_BITS    = 16;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 2;

    localparam int ACC_BITS      = SAMPLE_BITS + AVERAGE_SHIFT;
    localparam int CMP_BITS      = ((SAMPLE_BITS > MARGIN_BITS) ? SAMPLE_BITS
                                                                : MARGIN_BITS) + 1;
    localparam int SUM_BITS      = SAMPLE_BITS + $clog2(SEED_SCANS);
    localparam int SEED_CNT_BITS = $clog2(SEED_SCANS + 1);
    localparam int RECIP_SHIFT   = SUM_BITS + $clog2(SEED_SCANS);
    localparam int RECIP_BITS    = SUM_BITS + 1;
    localparam int PROD_BITS     = SUM_BITS + RECIP_BITS;

    localparam longint unsigned RECIP_FULL =
        ((64'd1 << RECIP_SHIFT) + 64'(SEED_SCANS) - 64'd1) / 64'(SEED_SCANS);
    localparam logic [RECIP_BITS-1:0] SEED_RECIP = RECIP_BITS'(RECIP_FULL);

    localparam logic [MARGIN_BITS-1:0]    MARGIN_RST    = MARGIN_BITS'(720);
    localparam logic [DEBOUNCE_BITS-1:0]  DEBOUNCE_RST  = DEBOUNCE_BITS'(250);
    localparam logic [WINDOW_BITS-1:0]    WINDOW_RST    = WINDOW_BITS'(150);
    localparam logic                      PAIR_MODE_RST = 1'b1;

    typedef enum logic [1:0] {
        REQ_DETECT = 2'd0,
        REQ_SEED   = 2'd1,
        REQ_CLEAR  = 2'd2
    } t_req;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_SPIKE_MARGIN = 2'd0,
        CFG_DEBOUNCE     = 2'd1,
        CFG_PAIR_WINDOW  = 2'd2,
        CFG_PAIR_MODE    = 2'd3
    } t_cfg_index;

    localparam logic EV_SINGLE = 1'b0;
    localparam logic EV_PAIR   = 1'b1;

    typedef struct packed {
        logic [MARGIN_BITS-1:0]    spike_margin;
        logic [DEBOUNCE_BITS-1:0]  lockout_ms;
        logic [WINDOW_BITS-1:0]    pair_window_ms;
        logic                      pair_mode;
    } t_cfg;

    typedef struct packed {
        logic [1:0]           req;
        logic                 first_valid;
        logic [SIDE_BITS-1:0] first_side;
        logic                 second_valid;
        logic [SIDE_BITS-1:0] second_side;
        logic [TIME_BITS-1:0] scan_time;
    } t_hit;

    function automatic logic [SIDE_BITS-1:0] opposite_of(input logic [SIDE_BITS-1:0] side);
        logic [SIDE_BITS:0] sum;
        sum = {1'b0, side} + (SIDE_BITS + 1)'(SIDE_COUNT / 2);
        if (sum >= (SIDE_BITS + 1)'(SIDE_COUNT)) begin
            sum = sum - (SIDE_BITS + 1)'(SIDE_COUNT);
        end
        return sum[SIDE_BITS-1:0];
    endfunction

endpackage
`default_nettype wire

>>> rtl/multi_channel_piezo_tap_detector.sv
// Top level of the eight-side piezo tap detector.
// Usage: a request on the input channel is taken when i_in_valid is high and o_in_stall
// is low. A detection scan carries one reading per side and the scan time, a seed scan
// adds the readings into the baseline seeding sums, and a clear request drops a held tap.
// Results leave on the output channel, one per cycle, when o_out_valid is high and
// i_out_stall is low; o_last_event marks the final result caused by a scan.
// Registers are written through the configuration channel, which is always ready;
// write them only while the block is idle.
// A scan moves through four stages: lane compare, strongest-spike pick, debounce, and
// pair tracking. One request is accepted every cycle while each scan yields at most
// one result and i_out_stall stays low; a scan with more results holds the result
// queue while they drain. After the last seed scan of a round the lanes divide their
// sums into the baselines, and no request is accepted while they do so.
// Reset loads the register defaults and clears baselines, seed sums, accept times and
// the held tap; baselines start at zero and are replaced when seeding completes.
// When the receiver stalls, the output register holds its result and the pipeline
// fills behind it, after which o_in_stall rises.
`default_nettype none
module multi_channel_piezo_tap_detector (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_req_type,
    input  logic [mcptd_pkg::SAMPLE_BITS-1:0]   i_reading_0,
    input  logic [mcptd_pkg::SAMPLE_BITS-1:0]   i_reading_1,
    input  logic [mcptd_pkg::SAMPLE_BITS-1:0]   i_reading_2,
    input  logic [mcptd_pkg::SAMPLE_BITS-1:0]   i_reading_3,
    input  logic [mcptd_pkg::SAMPLE_BITS-1:0]   i_reading_4,
    input  logic [mcptd_pkg::SAMPLE_BITS-1:0]   i_reading_5,
    input  logic [mcptd_pkg::SAMPLE_BITS-1:0]   i_reading_6,
    input  logic [mcptd_pkg::SAMPLE_BITS-1:0]   i_reading_7,
    input  logic [mcptd_pkg::TIME_BITS-1:0]     i_scan_time,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_event_kind,
    output logic [mcptd_pkg::SIDE_BITS-1:0]     o_tap_side,
    output logic [mcptd_pkg::TIME_BITS-1:0]     o_tap_time,
    output logic                                o_last_event,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mcptd_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [mcptd_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import mcptd_pkg::*;

    t_cfg                     r_cfg;
    logic [SEED_CNT_BITS-1:0] r_seed_cnt;
    logic                     r_seed_fin;
    logic                     r_a_valid;
    logic [1:0]               r_a_req;
    logic [TIME_BITS-1:0]     r_a_time;

    logic [SAMPLE_BITS-1:0]   w_reading [SIDE_COUNT];
    logic [SIDE_COUNT-1:0]    w_spike;
    logic [SAMPLE_BITS-1:0]   w_delta [SIDE_COUNT];
    logic                     w_accept;
    logic                     w_a_ready;
    logic                     w_b_ready;
    logic                     w_c_valid;
    t_hit                     w_hit;
    logic                     w_d_ready;

    assign w_reading[0] = i_reading_0;
    assign w_reading[1] = i_reading_1;
    assign w_reading[2] = i_reading_2;
    assign w_reading[3] = i_reading_3;
    assign w_reading[4] = i_reading_4;
    assign w_reading[5] = i_reading_5;
    assign w_reading[6] = i_reading_6;
    assign w_reading[7] = i_reading_7;

    assign w_a_ready   = !r_a_valid || w_b_ready;
    assign o_in_stall  = !w_a_ready || r_seed_fin;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.spike_margin   <= MARGIN_RST;
            r_cfg.lockout_ms     <= DEBOUNCE_RST;
            r_cfg.pair_window_ms <= WINDOW_RST;
            r_cfg.pair_mode      <= PAIR_MODE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SPIKE_MARGIN: r_cfg.spike_margin   <= i_cfg_data[MARGIN_BITS-1:0];
                CFG_DEBOUNCE:     r_cfg.lockout_ms     <= i_cfg_data[DEBOUNCE_BITS-1:0];
                CFG_PAIR_WINDOW:  r_cfg.pair_window_ms <= i_cfg_data[WINDOW_BITS-1:0];
                CFG_PAIR_MODE:    r_cfg.pair_mode      <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_cnt <= '0;
            r_seed_fin <= 1'b0;
            r_a_valid  <= 1'b0;
            r_a_req    <= '0;
            r_a_time   <= '0;
        end else begin
            r_seed_fin <= 1'b0;
            if (w_accept && (i_req_type == REQ_SEED)) begin
                if (r_seed_cnt == SEED_CNT_BITS'(SEED_SCANS - 1)) begin
                    r_seed_cnt <= '0;
                    r_seed_fin <= 1'b1;
                end else begin
                    r_seed_cnt <= r_seed_cnt + SEED_CNT_BITS'(1);
                end
            end
            if (w_accept) begin
                r_a_valid <= 1'b1;
                r_a_req   <= i_req_type;
                r_a_time  <= i_scan_time;
            end else if (w_b_ready) begin
                r_a_valid <= 1'b0;
            end
        end
    end

    for (genvar g = 0; g < SIDE_COUNT; g++) begin : g_lane
        mcptd_lane u_lane (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_load         (w_accept),
            .i_seed_fin     (r_seed_fin),
            .i_req          (i_req_type),
            .i_reading      (w_reading[g]),
            .i_spike_margin (r_cfg.spike_margin),
            .o_spike        (w_spike[g]),
            .o_delta        (w_delta[g])
        );
    end

    mcptd_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r_a_valid),
        .i_req        (r_a_req),
        .i_time       (r_a_time),
        .i_spike      (w_spike),
        .i_delta      (w_delta),
        .i_cfg        (r_cfg),
        .i_next_ready (w_d_ready),
        .o_ready      (w_b_ready),
        .o_valid      (w_c_valid),
        .o_hit        (w_hit)
    );

    mcptd_pair u_pair (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_c_valid),
        .i_hit        (w_hit),
        .i_cfg        (r_cfg),
        .o_ready      (w_d_ready),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_event_kind (o_event_kind),
        .o_tap_side   (o_tap_side),
        .o_tap_time   (o_tap_time),
        .o_last_event (o_last_event)
    );

`ifndef SYNTHESIS
    a_seed_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_req_type == REQ_SEED) && (r_seed_cnt == SEED_CNT_BITS'(SEED_SCANS - 1))
            |=> r_seed_fin && (r_seed_cnt == '0))
        else $error("seeding round did not finish after the last seed scan");
    a_seed_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seed_fin |-> o_in_stall)
        else $error("request accepted while baselines were being loaded");
    a_seed_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seed_fin |=> !r_seed_fin)
        else $error("baseline load lasted more than one cycle");
`endif

endmodule
`default_nettype wire

>>> rtl/mcptd_lane.sv
// One side's lane: spike test, moving-average baseline and seed accumulation.
`default_nettype none
module mcptd_lane (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_load,
    input  logic                                 i_seed_fin,
    input  logic [1:0]                           i_req,
    input  logic [mcptd_pkg::SAMPLE_BITS-1:0]    i_reading,
    input  logic [mcptd_pkg::MARGIN_BITS-1:0]    i_spike_margin,
    output logic                                 o_spike,
    output logic [mcptd_pkg::SAMPLE_BITS-1:0]    o_delta
);
    import mcptd_pkg::*;

    logic [ACC_BITS-1:0]    r_acc;
    logic [SUM_BITS-1:0]    r_sum;
    logic                   r_spike;
    logic [SAMPLE_BITS-1:0] r_delta;

    logic [SAMPLE_BITS-1:0] w_base;
    logic [CMP_BITS-1:0]    w_thresh;
    logic                   w_spike;
    logic [ACC_BITS:0]      w_grow;
    logic [PROD_BITS-1:0]   w_prod;
    logic [SAMPLE_BITS-1:0] w_quot;

    assign w_base   = r_acc[ACC_BITS-1:AVERAGE_SHIFT];
    assign w_thresh = CMP_BITS'(w_base) + CMP_BITS'(i_spike_margin);
    assign w_spike  = CMP_BITS'(i_reading) > w_thresh;
    assign w_grow   = (ACC_BITS + 1)'(r_acc) + (ACC_BITS + 1)'(i_reading)
                    - (ACC_BITS + 1)'(w_base);
    assign w_prod   = PROD_BITS'(r_sum) * PROD_BITS'(SEED_RECIP);
    assign w_quot   = w_prod[RECIP_SHIFT +: SAMPLE_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_sum   <= '0;
            r_spike <= 1'b0;
            r_delta <= '0;
        end else if (i_seed_fin) begin
            r_acc <= {w_quot, {AVERAGE_SHIFT{1'b0}}};
            r_sum <= '0;
        end else if (i_load) begin
            r_spike <= (i_req == REQ_DETECT) && w_spike;
            r_delta <= i_reading - w_base;
            if ((i_req == REQ_DETECT) && !w_spike) begin
                r_acc <= w_grow[ACC_BITS-1:0];
            end
            if (i_req == REQ_SEED) begin
                r_sum <= r_sum + SUM_BITS'(i_reading);
            end
        end
    end

    assign o_spike = r_spike;
    assign o_delta = r_delta;

endmodule
`default_nettype wire

>>> rtl/mcptd_merge.sv
// Merging stages: picks the strongest spike, then applies per-side debounce.
`default_nettype none
module mcptd_merge (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic [1:0]                         i_req,
    input  logic [mcptd_pkg::TIME_BITS-1:0]    i_time,
    input  logic [mcptd_pkg::SIDE_COUNT-1:0]   i_spike,
    input  logic [mcptd_pkg::SAMPLE_BITS-1:0]  i_delta [mcptd_pkg::SIDE_COUNT],
    input  mcptd_pkg::t_cfg                    i_cfg,
    input  logic                               i_next_ready,
    output logic                               o_ready,
    output logic                               o_valid,
    output mcptd_pkg::t_hit                    o_hit
);
    import mcptd_pkg::*;

    logic                   r_b_valid;
    logic [1:0]             r_b_req;
    logic [TIME_BITS-1:0]   r_b_time;
    logic                   r_b_found;
    logic [SIDE_BITS-1:0]   r_b_best;
    logic [SIDE_COUNT-1:0]  r_b_spiked;

    logic                   r_c_valid;
    t_hit                   r_c_hit;
    logic [TIME_BITS-1:0]   r_last [SIDE_COUNT];

    logic                   w_found;
    logic [SIDE_BITS-1:0]   w_best;
    logic [SAMPLE_BITS-1:0] w_best_delta;
    logic [SIDE_COUNT-1:0]  w_ok;
    logic [SIDE_BITS-1:0]   w_opp;
    logic                   w_take_best;
    logic                   w_take_opp;
    logic [SIDE_COUNT-1:0]  w_hit_mask;
    t_hit                   n_hit;
    logic                   w_b_ready;
    logic                   w_c_ready;
    logic                   w_b_load;
    logic                   w_c_load;

    assign w_c_ready = !r_c_valid || i_next_ready;
    assign w_b_ready = !r_b_valid || w_c_ready;
    assign w_b_load  = i_valid && w_b_ready;
    assign w_c_load  = r_b_valid && w_c_ready;
    assign o_ready   = w_b_ready;

    always_comb begin
        w_found      = 1'b0;
        w_best       = '0;
        w_best_delta = '0;
        for (int i = 0; i < SIDE_COUNT; i++) begin
            if (i_spike[i] && (i_delta[i] > w_best_delta)) begin
                w_found      = 1'b1;
                w_best       = SIDE_BITS'(i);
                w_best_delta = i_delta[i];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < SIDE_COUNT; i++) begin
            w_ok[i] = (r_b_time - r_last[i]) > TIME_BITS'(i_cfg.lockout_ms);
        end
    end

    assign w_opp       = opposite_of(r_b_best);
    assign w_take_best = (r_b_req == REQ_DETECT) && r_b_found && w_ok[r_b_best];
    assign w_take_opp  = w_take_best && r_b_spiked[w_opp] && w_ok[w_opp];

    always_comb begin
        w_hit_mask = '0;
        if (w_take_best) begin
            w_hit_mask[r_b_best] = 1'b1;
        end
        if (w_take_opp) begin
            w_hit_mask[w_opp] = 1'b1;
        end
        n_hit.req          = r_b_req;
        n_hit.scan_time    = r_b_time;
        n_hit.first_valid  = w_take_best;
        n_hit.first_side   = r_b_best;
        n_hit.second_valid = w_take_opp;
        n_hit.second_side  = w_opp;
        if (w_take_opp && (w_opp < r_b_best)) begin
            n_hit.first_side  = w_opp;
            n_hit.second_side = r_b_best;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid  <= 1'b0;
            r_b_req    <= '0;
            r_b_time   <= '0;
            r_b_found  <= 1'b0;
            r_b_best   <= '0;
            r_b_spiked <= '0;
            r_c_valid  <= 1'b0;
            r_c_hit    <= '0;
            for (int i = 0; i < SIDE_COUNT; i++) begin
                r_last[i] <= '0;
            end
        end else begin
            if (w_b_load) begin
                r_b_valid  <= 1'b1;
                r_b_req    <= i_req;
                r_b_time   <= i_time;
                r_b_found  <= w_found;
                r_b_best   <= w_best;
                r_b_spiked <= i_spike;
            end else if (w_c_ready) begin
                r_b_valid <= 1'b0;
            end
            if (w_c_load) begin
                r_c_valid <= 1'b1;
                r_c_hit   <= n_hit;
                for (int i = 0; i < SIDE_COUNT; i++) begin
                    if (w_hit_mask[i]) begin
                        r_last[i] <= r_b_time;
                    end
                end
            end else if (i_next_ready) begin
                r_c_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_c_valid;
    assign o_hit   = r_c_hit;

`ifndef SYNTHESIS
    a_hit_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_valid && r_c_hit.second_valid |->
            r_c_hit.first_valid && (r_c_hit.first_side < r_c_hit.second_side))
        else $error("second hit without an earlier first hit");
    a_hit_detect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_valid && r_c_hit.first_valid |-> r_c_hit.req == REQ_DETECT)
        else $error("hit reported on a request that is not a detection scan");
    a_last_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_c_load && w_take_best |=> r_last[$past(r_b_best)] == $past(r_b_time))
        else $error("accept time of the winning side was not updated");
`endif

endmodule
`default_nettype wire

>>> rtl/mcptd_pair.sv
// Pair tracking of held taps and the result queue feeding the output register.
`default_nettype none
module mcptd_pair (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  mcptd_pkg::t_hit                    i_hit,
    input  mcptd_pkg::t_cfg                    i_cfg,
    output logic                               o_ready,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_event_kind,
    output logic [mcptd_pkg::SIDE_BITS-1:0]    o_tap_side,
    output logic [mcptd_pkg::TIME_BITS-1:0]    o_tap_time,
    output logic                               o_last_event
);
    import mcptd_pkg::*;

    typedef struct packed {
        logic                 kind;
        logic [SIDE_BITS-1:0] side;
        logic [TIME_BITS-1:0] tap_time;
    } t_result;

    logic                 r_held_valid;
    logic [SIDE_BITS-1:0] r_held_side;
    logic [TIME_BITS-1:0] r_held_time;
    t_result              r_q [3];
    logic [1:0]           r_q_cnt;
    logic                 r_out_valid;
    t_result              r_out;
    logic                 r_out_last;

    logic                 n_held_valid;
    logic [SIDE_BITS-1:0] n_held_side;
    logic [TIME_BITS-1:0] n_held_time;
    t_result              w_res [3];
    logic [1:0]           w_cnt;
    logic                 w_fresh;
    logic                 w_window_done;
    logic [1:0]           w_hit_valid;
    logic [SIDE_BITS-1:0] w_hit_side [2];
    logic                 w_drain;
    logic                 w_load;

    assign w_drain = (r_q_cnt != 2'd0) && (!r_out_valid || !i_out_stall);
    assign o_ready = (r_q_cnt == 2'd0) || ((r_q_cnt == 2'd1) && w_drain);
    assign w_load  = i_valid && o_ready;

    assign w_hit_valid   = {i_hit.second_valid, i_hit.first_valid};
    assign w_hit_side[0] = i_hit.first_side;
    assign w_hit_side[1] = i_hit.second_side;
    assign w_window_done = (i_hit.scan_time - r_held_time) >= TIME_BITS'(i_cfg.pair_window_ms);

    always_comb begin
        n_held_valid = r_held_valid;
        n_held_side  = r_held_side;
        n_held_time  = r_held_time;
        w_fresh      = 1'b0;
        w_cnt        = 2'd0;
        for (int k = 0; k < 3; k++) begin
            w_res[k] = '0;
        end
        if (i_hit.req == REQ_DETECT) begin
            for (int k = 0; k < 2; k++) begin
                if (w_hit_valid[k]) begin
                    if (!i_cfg.pair_mode) begin
                        w_res[w_cnt] = '{EV_SINGLE, w_hit_side[k], i_hit.scan_time};
                        w_cnt = w_cnt + 2'd1;
                    end else if (n_held_valid && (opposite_of(n_held_side) == w_hit_side[k])) begin
                        n_held_valid = 1'b0;
                        w_res[w_cnt] = '{EV_PAIR, w_hit_side[k], i_hit.scan_time};
                        w_cnt = w_cnt + 2'd1;
                    end else begin
                        if (n_held_valid) begin
                            w_res[w_cnt] = '{EV_SINGLE, n_held_side, n_held_time};
                            w_cnt = w_cnt + 2'd1;
                        end
                        n_held_valid = 1'b1;
                        n_held_side  = w_hit_side[k];
                        n_held_time  = i_hit.scan_time;
                        w_fresh      = 1'b1;
                    end
                end
            end
            if (i_cfg.pair_mode && n_held_valid) begin
                if (w_fresh ? (i_cfg.pair_window_ms == '0) : w_window_done) begin
                    n_held_valid = 1'b0;
                    w_res[w_cnt] = '{EV_SINGLE, n_held_side, n_held_time};
                    w_cnt = w_cnt + 2'd1;
                end
            end
        end else if (i_hit.req == REQ_CLEAR) begin
            n_held_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_held_side  <= '0;
            r_held_time  <= '0;
            r_q_cnt      <= 2'd0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_load) begin
                r_held_valid <= n_held_valid;
                r_held_side  <= n_held_side;
                r_held_time  <= n_held_time;
                r_q          <= w_res;
                r_q_cnt      <= w_cnt;
            end else if (w_drain) begin
                r_q[0]  <= r_q[1];
                r_q[1]  <= r_q[2];
                r_q_cnt <= r_q_cnt - 2'd1;
            end
            if (w_drain) begin
                r_out_valid <= 1'b1;
                r_out       <= r_q[0];
                r_out_last  <= (r_q_cnt == 2'd1);
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_event_kind = r_out.kind;
    assign o_tap_side   = r_out.side;
    assign o_tap_time   = r_out.tap_time;
    assign o_last_event = r_out_last;

`ifndef SYNTHESIS
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_drain && (r_q_cnt == 2'd1) |=> r_out_last)
        else $error("final result of a scan is not marked last");
    a_queue_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> r_q_cnt == $past(w_cnt))
        else $error("result queue count does not match the scan's results");
    a_clear_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load && (i_hit.req == REQ_CLEAR) |=> !r_held_valid)
        else $error("held tap survived a clear request");
`endif

endmodule
`default_nettype wire
